/* rtl/sme_pkg.sv */
// Shared types and constants for the sparse matrix entry store.
// Used by the entry cell, the top level and the port checker; depends on nothing.
`default_nettype none

package sme_pkg;

    // Field widths fixed by the request and result formats.
    localparam int OP_BITS         = 2;
    localparam int ROW_BITS        = 8;
    localparam int COL_BITS        = 8;
    localparam int VALUE_PORT_BITS = 32;
    localparam int STATUS_BITS     = 2;
    localparam int WIDE_BITS       = 64;

    // Configuration registers.
    localparam int CNT_BITS     = 9;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CNT_BITS-1:0] CNT_RESET = 9'd256;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = 1'b1;

    // Default parameter values.
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_ADD   = 2'd2;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // Control part of the search token that walks the cell chain.
    typedef struct packed {
        logic                valid;
        logic [OP_BITS-1:0]  op;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                hit;
        logic                free_found;
    } t_tok;

    // Insert command broadcast to the cells when a token leaves the chain.
    typedef struct packed {
        logic                en;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } t_cmt;

endpackage

`default_nettype wire

/* rtl/sparse_matrix_entry_store.sv */
// Top level of the sparse matrix entry store: request port, config registers,
// the chain of sme_cell instances and the result register. Depends on sme_pkg, sme_cell.
`default_nettype none

// Usage
// The store holds up to CAPACITY nonzero entries, each keyed by (row, col).
// A request on the input channel (i_in_valid / o_in_stall) carries an op code,
// a row, a column and a value. A read returns the stored value or zero, a write
// of a nonzero value updates or inserts, a write of zero deletes, and an add
// accumulates, freeing the entry when the sum becomes zero. Every request gives
// exactly one result on the output channel (o_out_valid / i_out_stall) with the
// value after the operation and a status: ok, index out of range, or store full.
// A request whose row or column is not below the configured counts is answered
// in the cycle after it is accepted and leaves the store unchanged. Any other
// request walks the chain of CAPACITY cells, one cell per cycle, and its result
// is registered as its token leaves the last cell. One request is in the chain at
// a time, so no new request is taken until an in-range request's result is
// registered. A new request may be accepted in the same cycle that a waiting
// result is taken. While the receiver stalls, the result holds and no new
// request is taken. Reset clears every entry and sets both counts to 256;
// configuration writes take effect at once and are meant for idle time.

module sparse_matrix_entry_store #(
    parameter int CAPACITY   = sme_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sme_pkg::VALUE_BITS_DEF
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    // Configuration write port.
    input  wire                                        i_cfg_we,
    input  wire         [sme_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire         [sme_pkg::CNT_BITS-1:0]        i_cfg_data,
    // Request channel.
    input  wire                                        i_in_valid,
    output logic                                       o_in_stall,
    input  wire         [sme_pkg::OP_BITS-1:0]         i_op,
    input  wire         [sme_pkg::ROW_BITS-1:0]        i_row,
    input  wire         [sme_pkg::COL_BITS-1:0]        i_col,
    input  wire signed  [sme_pkg::VALUE_PORT_BITS-1:0] i_value,
    // Result channel.
    output logic                                       o_out_valid,
    input  wire                                        i_out_stall,
    output logic signed [sme_pkg::VALUE_PORT_BITS-1:0] o_read_value,
    output logic        [sme_pkg::STATUS_BITS-1:0]     o_status
);

    localparam int IDX_BITS = $clog2(CAPACITY);

    // Configuration registers.
    logic [sme_pkg::CNT_BITS-1:0] r_row_count;
    logic [sme_pkg::CNT_BITS-1:0] r_col_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= sme_pkg::CNT_RESET;
            r_col_count <= sme_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sme_pkg::REG_ROW_COUNT: r_row_count <= i_cfg_data;
                sme_pkg::REG_COL_COUNT: r_col_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Token links between cells: link 0 is fed here, link CAPACITY returns here.
    sme_pkg::t_tok         w_tok       [CAPACITY+1];
    logic [VALUE_BITS-1:0] w_tok_value [CAPACITY+1];
    logic [VALUE_BITS-1:0] w_tok_result[CAPACITY+1];
    logic [IDX_BITS-1:0]   w_tok_free  [CAPACITY+1];

    sme_pkg::t_cmt         w_cmt;
    logic [IDX_BITS-1:0]   w_cmt_idx;
    logic [VALUE_BITS-1:0] w_cmt_value;

    // Control and result registers.
    logic                                r_run;
    logic                                r_out_valid;
    logic [sme_pkg::VALUE_PORT_BITS-1:0] r_read_value;
    logic [sme_pkg::STATUS_BITS-1:0]     r_status;

    logic                                n_run;
    logic                                n_out_valid;
    logic [sme_pkg::VALUE_PORT_BITS-1:0] n_read_value;
    logic [sme_pkg::STATUS_BITS-1:0]     n_status;

    logic                          w_accept;
    logic                          w_out_range;
    logic [sme_pkg::WIDE_BITS-1:0] w_in_wide;
    logic [VALUE_BITS-1:0]         w_in_value;

    // The request is idle-gated: nothing in the chain, and the result slot free
    // or being emptied in this cycle.
    assign o_in_stall = r_run || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_out_range = (sme_pkg::CNT_BITS'(i_row) >= r_row_count) ||
                         (sme_pkg::CNT_BITS'(i_col) >= r_col_count);

    // The operand is sign-extended and then cut to the stored width.
    assign w_in_wide  = sme_pkg::WIDE_BITS'(i_value);
    assign w_in_value = w_in_wide[VALUE_BITS-1:0];

    // An in-range request enters the first cell in the cycle it is accepted.
    always_comb begin
        w_tok[0].valid      = w_accept && !w_out_range;
        w_tok[0].op         = i_op;
        w_tok[0].row        = i_row;
        w_tok[0].col        = i_col;
        w_tok[0].hit        = 1'b0;
        w_tok[0].free_found = 1'b0;
        w_tok_value[0]      = w_in_value;
        w_tok_result[0]     = '0;
        w_tok_free[0]       = '0;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sme_cell #(
            .CELL_IDX   (g),
            .IDX_BITS   (IDX_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_tok          (w_tok[g]),
            .i_tok_value    (w_tok_value[g]),
            .i_tok_result   (w_tok_result[g]),
            .i_tok_free_idx (w_tok_free[g]),
            .i_cmt          (w_cmt),
            .i_cmt_idx      (w_cmt_idx),
            .i_cmt_value    (w_cmt_value),
            .o_tok          (w_tok[g+1]),
            .o_tok_value    (w_tok_value[g+1]),
            .o_tok_result   (w_tok_result[g+1]),
            .o_tok_free_idx (w_tok_free[g+1])
        );
    end

    // Finishing a token. A match was already handled inside its cell. A write or
    // add of a nonzero value that found no key needs an insert: it goes to the
    // lowest free cell the token saw, or reports a full store when it saw none.
    sme_pkg::t_tok                   w_last;
    logic                            w_last_mod;
    logic                            w_need_insert;
    logic signed [VALUE_BITS-1:0]    w_final;
    logic [sme_pkg::STATUS_BITS-1:0] w_final_status;
    logic [sme_pkg::WIDE_BITS-1:0]   w_final_wide;

    assign w_last        = w_tok[CAPACITY];
    assign w_last_mod    = (w_last.op == sme_pkg::OP_WRITE) || (w_last.op == sme_pkg::OP_ADD);
    assign w_need_insert = w_last.valid && !w_last.hit && w_last_mod &&
                           (w_tok_value[CAPACITY] != '0);

    assign w_cmt.en    = w_need_insert && w_last.free_found;
    assign w_cmt.row   = w_last.row;
    assign w_cmt.col   = w_last.col;
    assign w_cmt_idx   = w_tok_free[CAPACITY];
    assign w_cmt_value = w_tok_value[CAPACITY];

    always_comb begin
        if (w_need_insert) begin
            w_final        = w_last.free_found ? w_tok_value[CAPACITY] : '0;
            w_final_status = w_last.free_found ? sme_pkg::ST_OK : sme_pkg::ST_FULL;
        end else begin
            w_final        = w_tok_result[CAPACITY];
            w_final_status = sme_pkg::ST_OK;
        end
    end

    // The stored value is sign-extended before it is cut to the port width.
    assign w_final_wide = sme_pkg::WIDE_BITS'(w_final);

    always_comb begin
        n_run        = r_run;
        n_out_valid  = r_out_valid;
        n_read_value = r_read_value;
        n_status     = r_status;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            if (w_out_range) begin
                n_out_valid  = 1'b1;
                n_read_value = '0;
                n_status     = sme_pkg::ST_RANGE;
            end else begin
                n_run = 1'b1;
            end
        end
        // The result slot is always empty when a token leaves the chain.
        if (w_last.valid) begin
            n_run        = 1'b0;
            n_out_valid  = 1'b1;
            n_read_value = w_final_wide[sme_pkg::VALUE_PORT_BITS-1:0];
            n_status     = w_final_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_value <= n_read_value;
        r_status     <= n_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

endmodule

`default_nettype wire

/* rtl/sme_cell.sv */
// One storage cell of the entry chain: holds one entry and one token stage.
// Depends on sme_pkg.
`default_nettype none

module sme_cell #(
    parameter int CELL_IDX   = 0,
    parameter int IDX_BITS   = 6,
    parameter int VALUE_BITS = sme_pkg::VALUE_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  sme_pkg::t_tok            i_tok,
    input  wire     [VALUE_BITS-1:0] i_tok_value,
    input  wire     [VALUE_BITS-1:0] i_tok_result,
    input  wire     [IDX_BITS-1:0]   i_tok_free_idx,
    input  sme_pkg::t_cmt            i_cmt,
    input  wire     [IDX_BITS-1:0]   i_cmt_idx,
    input  wire     [VALUE_BITS-1:0] i_cmt_value,
    output sme_pkg::t_tok            o_tok,
    output logic    [VALUE_BITS-1:0] o_tok_value,
    output logic    [VALUE_BITS-1:0] o_tok_result,
    output logic    [IDX_BITS-1:0]   o_tok_free_idx
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic                         r_valid;
    logic [sme_pkg::ROW_BITS-1:0] r_row;
    logic [sme_pkg::COL_BITS-1:0] r_col;
    logic [VALUE_BITS-1:0]        r_value;

    sme_pkg::t_tok         r_tok;
    logic [VALUE_BITS-1:0] r_tok_value;
    logic [VALUE_BITS-1:0] r_tok_result;
    logic [IDX_BITS-1:0]   r_tok_free_idx;

    logic                  w_is_mod;
    logic                  w_match;
    logic                  w_cmt_hit;
    logic [VALUE_BITS-1:0] w_new_value;
    logic                  w_new_zero;

    assign w_is_mod    = (i_tok.op == sme_pkg::OP_WRITE) || (i_tok.op == sme_pkg::OP_ADD);
    assign w_match     = i_tok.valid && r_valid && (r_row == i_tok.row) && (r_col == i_tok.col);
    assign w_cmt_hit   = i_cmt.en && (i_cmt_idx == MY_IDX);
    assign w_new_value = (i_tok.op == sme_pkg::OP_WRITE) ? i_tok_value : (r_value + i_tok_value);
    assign w_new_zero  = (w_new_value == '0);

    // Entry state: an insert from the top level, or an update or delete on a match.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_cmt_hit) begin
            r_valid <= 1'b1;
        end else if (w_match && w_is_mod && w_new_zero) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmt_hit) begin
            r_row   <= i_cmt.row;
            r_col   <= i_cmt.col;
            r_value <= i_cmt_value;
        end else if (w_match && w_is_mod && !w_new_zero) begin
            r_value <= w_new_value;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_tok.op         <= i_tok.op;
            r_tok.row        <= i_tok.row;
            r_tok.col        <= i_tok.col;
            r_tok.hit        <= i_tok.hit || w_match;
            r_tok.free_found <= i_tok.free_found || !r_valid;
            r_tok_value      <= i_tok_value;
            r_tok_free_idx   <= i_tok.free_found ? i_tok_free_idx : MY_IDX;
            if (w_match) begin
                if (!w_is_mod) begin
                    r_tok_result <= r_value;
                end else if (w_new_zero) begin
                    r_tok_result <= '0;
                end else begin
                    r_tok_result <= w_new_value;
                end
            end else begin
                r_tok_result <= i_tok_result;
            end
        end
    end

    assign o_tok          = r_tok;
    assign o_tok_value    = r_tok_value;
    assign o_tok_result   = r_tok_result;
    assign o_tok_free_idx = r_tok_free_idx;

endmodule

`default_nettype wire

/* rtl/sme_checker.sv */
// Port-level checks for the sparse matrix entry store, bound to its top level.
// Depends on sme_pkg and sparse_matrix_entry_store.
`default_nettype none

module sme_checker (
    input wire                                       i_clk,
    input wire                                       i_rst_n,
    input wire                                       i_cfg_we,
    input wire        [sme_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input wire        [sme_pkg::CNT_BITS-1:0]        i_cfg_data,
    input wire                                       i_in_valid,
    input wire                                       o_in_stall,
    input wire        [sme_pkg::ROW_BITS-1:0]        i_row,
    input wire        [sme_pkg::COL_BITS-1:0]        i_col,
    input wire                                       o_out_valid,
    input wire                                       i_out_stall,
    input wire signed [sme_pkg::VALUE_PORT_BITS-1:0] o_read_value,
    input wire        [sme_pkg::STATUS_BITS-1:0]     o_status
);

    // Copy of the index limits, kept from the configuration writes.
    logic [sme_pkg::CNT_BITS-1:0] r_rows;
    logic [sme_pkg::CNT_BITS-1:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= sme_pkg::CNT_RESET;
            r_cols <= sme_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sme_pkg::REG_ROW_COUNT) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_index == sme_pkg::REG_COL_COUNT) begin
                r_cols <= i_cfg_data;
            end
        end
    end

    logic w_accept;
    logic w_bad_index;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_bad_index = (sme_pkg::CNT_BITS'(i_row) >= r_rows) ||
                         (sme_pkg::CNT_BITS'(i_col) >= r_cols);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_value) && $stable(o_status))
        else $error("result changed or dropped while stalled");

    a_no_accept_on_stalled_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("request taken while a result is stalled");

    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_bad_index |=> o_out_valid && (o_status == sme_pkg::ST_RANGE))
        else $error("out-of-range request not answered next cycle");

    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != sme_pkg::ST_OK) |-> (o_read_value == '0))
        else $error("error result carries a nonzero value");

    a_no_accept_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_bad_index |=> !o_out_valid && o_in_stall)
        else $error("in-range request answered or overlapped too early");

endmodule

bind sparse_matrix_entry_store sme_checker u_sme_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_index  (i_cfg_index),
    .i_cfg_data   (i_cfg_data),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_row        (i_row),
    .i_col        (i_col),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);

`default_nettype wire
